// ----- hdl/lav_pkg.sv -----
// Shared types and state encodings for the look-at view matrix block.
package lav_pkg;

  // One input item: eye point, target point, zoom scale.
  typedef struct packed {
    logic signed [31:0] eye_px;
    logic signed [31:0] eye_py;
    logic signed [31:0] eye_pz;
    logic signed [31:0] target_px;
    logic signed [31:0] target_py;
    logic signed [31:0] target_pz;
    logic        [30:0] zoom_factor;
  } in_item_t;

  // One result item: a single matrix row.
  typedef struct packed {
    logic        [1:0]  row_index;
    logic signed [31:0] col_zero;
    logic signed [31:0] col_one;
    logic signed [31:0] col_two;
    logic signed [31:0] col_three;
    logic               degenerate;
    logic               last_row;
  } out_item_t;

  // Queued job: eye, view direction (target - eye) and zoom.
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][32:0] dir;
    logic [30:0]      zoom;
  } job_t;

  typedef enum logic [2:0] {
    U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_DIV, U_DONE
  } unit_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_FWD, B_SIDE, B_CROSS, B_UPX, B_PROD, B_ROWS
  } back_state_t;

endpackage

// ----- hdl/lav_front.sv -----
// Front end: accepts items, forms the view direction, queues jobs.
module lav_front import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t item,
  output logic     busy,
  input  logic     pop,
  output job_t     job,
  output logic     job_valid
);

  job_t       q [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic       push;
  job_t       fill;

  assign busy      = (cnt == 2'd2);
  assign push      = start && !busy;
  assign job       = q[rp];
  assign job_valid = (cnt != 2'd0);

  // direction = target - eye at 33 bits
  always_comb begin
    fill.eye[0] = item.eye_px;
    fill.eye[1] = item.eye_py;
    fill.eye[2] = item.eye_pz;
    fill.dir[0] = {item.target_px[31], item.target_px} - {item.eye_px[31], item.eye_px};
    fill.dir[1] = {item.target_py[31], item.target_py} - {item.eye_py[31], item.eye_py};
    fill.dir[2] = {item.target_pz[31], item.target_pz} - {item.eye_pz[31], item.eye_pz};
    fill.zoom   = item.zoom_factor;
  end

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        q[wp] <= fill;
        wp    <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/lav_unit.sv -----
// Unit-vector engine: prescale, sum of squares, integer sqrt, three divides.
module lav_unit import lav_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int MW        = 33
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [2:0][MW:0]            vec,
  output logic                        done,
  output logic                        ok,
  output logic [2:0][FRAC_BITS+1:0]   u
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int SCW = $clog2(FRAC_BITS + 1);

  unit_state_t         state, state_next;
  logic [2:0]          neg;
  logic [MW-1:0]       m [3];
  logic [MW:0]         vmag [3];
  logic [MW-1:0]       big;
  logic                hi, lo;
  logic [1:0]          k;
  logic [29:0]         sq_op;
  logic [59:0]         prod;
  logic [61:0]         sum, x, res, bt, t;
  logic                ge;
  logic [31:0]         r, len, rs;
  logic                cmp;
  logic [FRAC_BITS:0]  q, qf;
  logic [UW-1:0]       uq;
  logic [1:0]          ci;
  logic [SCW-1:0]      sc;
  logic [MW-1:0]       m_next_comp;

  assign done = (state == U_DONE);

  always_comb begin
    for (int i = 0; i < 3; i++)
      vmag[i] = vec[i][MW] ? (~vec[i] + 1'b1) : vec[i];
    big = (m[0] > m[1]) ? m[0] : m[1];
    big = (m[2] > big) ? m[2] : big;
    hi  = |big[MW-1:30];
    lo  = !(|big[MW-1:29]);
    sq_op = (k == 2'd3) ? 30'd0 : m[k][29:0];
    // one isqrt step
    t  = res + bt;
    ge = (x >= t);
    // one restoring divide step
    len = {1'b0, res[30:0]};
    cmp = (r >= len);
    rs  = cmp ? (r - len) : r;
    qf  = {q[FRAC_BITS-1:0], cmp};
    uq  = {1'b0, qf};
    m_next_comp = (ci == 2'd0) ? m[1] : m[2];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE:  if (go) state_next = U_SHIFT;
      U_SHIFT: begin
        if (big == '0) state_next = U_DONE;
        else if (!hi && !lo) state_next = U_SQ;
      end
      U_SQ:    if (k == 2'd3) state_next = U_SQRT;
      U_SQRT:  if (bt[0]) state_next = U_DIV;
      U_DIV:   if (sc == SCW'(FRAC_BITS) && ci == 2'd2) state_next = U_DONE;
      U_DONE:  state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= U_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: if (go) begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vec[i][MW];
          m[i]   <= vmag[i][MW-1:0];
        end
      end
      U_SHIFT: begin
        if (big == '0) begin
          ok <= 1'b0;
          u  <= '0;
        end else if (hi) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else if (lo) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end else begin
          ok   <= 1'b1;
          k    <= 2'd0;
          sum  <= '0;
          prod <= '0;
        end
      end
      U_SQ: begin
        prod <= sq_op * sq_op;
        sum  <= sum + {2'b00, prod};
        k    <= k + 2'd1;
        if (k == 2'd3) begin
          x   <= sum + {2'b00, prod};
          res <= '0;
          bt  <= 62'd1 << 60;
        end
      end
      U_SQRT: begin
        if (ge) begin
          x   <= x - t;
          res <= (res >> 1) + bt;
        end else begin
          res <= res >> 1;
        end
        bt <= bt >> 2;
        if (bt[0]) begin
          ci <= 2'd0;
          sc <= '0;
          r  <= {2'b00, m[0][29:0]};
        end
      end
      U_DIV: begin
        q <= qf;
        if (sc == SCW'(FRAC_BITS)) begin
          u[ci] <= neg[ci] ? (~uq + 1'b1) : uq;
          ci    <= ci + 2'd1;
          sc    <= '0;
          r     <= {2'b00, m_next_comp[29:0]};
        end else begin
          sc <= sc + 1'b1;
          r  <= {rs[30:0], 1'b0};
        end
      end
      U_DONE: ;
      default: ;
    endcase
  end

endmodule

// ----- hdl/lav_back.sv -----
// Back end: builds the three axes, scales them, forms translation, emits rows.
module lav_back import lav_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_valid,
  output logic      pop,
  output logic      strobe,
  output out_item_t result
);

  localparam int UW = FRAC_BITS + 2;
  localparam int MW = (2 * FRAC_BITS + 2 > 33) ? 2 * FRAC_BITS + 2 : 33;
  localparam int PW = UW + 33;
  localparam int AW = PW + 2;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] MAXV = AW'(32'h7fffffff);
  localparam logic signed [AW-1:0] MINV = {{(AW-32){1'b1}}, 32'h80000000};

  back_state_t          state, state_next;
  logic [2:0][31:0]     eye;
  logic [2:0][32:0]     dir;
  logic [30:0]          zoom;
  logic [2:0][UW-1:0]   fwd, side, upx, uvec;
  logic [2:0][MW:0]     cv, uin;
  logic                 ok, issued, u_go, u_done, u_ok;
  logic [2:0]           cnt;
  logic signed [UW-1:0] mul_a;
  logic signed [32:0]   mul_b;
  logic signed [PW-1:0] p;
  logic signed [AW-1:0] acc, pext, dot, diff;
  logic                 ph, pph, pv, iss_done;
  logic [1:0]           ax, cp, pax, pcp, row;
  logic [UW-1:0]        axc;
  logic [UW-1:0]        nf0;
  logic [31:0]          ent [4][3];

  function automatic logic [31:0] rnd_sat(input logic signed [AW-1:0] v,
                                          input logic negate);
    logic [AW-1:0]        mag;
    logic signed [AW-1:0] rv;
    mag = v[AW-1] ? (~v + 1'b1) : v;
    mag = (mag + HALF) >> FRAC_BITS;
    rv  = v[AW-1] ? $signed(~mag + 1'b1) : $signed(mag);
    if (negate) rv = -rv;
    if (rv > MAXV)      return 32'h7fffffff;
    else if (rv < MINV) return 32'h80000000;
    else                return rv[31:0];
  endfunction

  lav_unit #(.FRAC_BITS(FRAC_BITS), .MW(MW)) u_unit (
    .clk  (clk),
    .rst  (rst),
    .go   (u_go),
    .vec  (uin),
    .done (u_done),
    .ok   (u_ok),
    .u    (uvec)
  );

  // unit launch and operand select
  always_comb begin
    u_go = (state == B_FWD || state == B_SIDE || state == B_UPX) && !issued;
    nf0  = ~fwd[0] + 1'b1;
    uin  = cv;
    unique case (state)
      B_FWD: for (int i = 0; i < 3; i++) uin[i] = {{(MW-32){dir[i][32]}}, dir[i]};
      B_SIDE: begin
        uin[0] = {{(MW+1-UW){fwd[2][UW-1]}}, fwd[2]};
        uin[1] = '0;
        uin[2] = {{(MW+1-UW){nf0[UW-1]}}, nf0};
      end
      default: uin = cv;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ax)
      2'd0:    axc = side[cp];
      2'd1:    axc = upx[cp];
      default: axc = fwd[cp];
    endcase
    if (state == B_CROSS) begin
      unique case (cnt)
        3'd0: begin mul_a = fwd[1]; mul_b = 33'($signed(side[2])); end
        3'd1: begin mul_a = fwd[2]; mul_b = 33'($signed(side[0])); end
        3'd2: begin mul_a = fwd[0]; mul_b = 33'($signed(side[2])); end
        3'd3: begin mul_a = fwd[1]; mul_b = 33'($signed(side[0])); end
        default: ;
      endcase
    end else if (state == B_PROD) begin
      mul_a = axc;
      mul_b = ph ? $signed({eye[cp][31], eye[cp]}) : $signed({2'b00, zoom});
    end
    pext = {{(AW-PW){p[PW-1]}}, p};
    dot  = ((pcp == 2'd0) ? '0 : acc) + pext;
    diff = acc - pext;
  end

  // next state
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: if (job_valid) begin
        pop        = 1'b1;
        state_next = B_FWD;
      end
      B_FWD:   if (u_done) state_next = B_SIDE;
      B_SIDE:  if (u_done) state_next = B_CROSS;
      B_CROSS: if (cnt == 3'd4) state_next = B_UPX;
      B_UPX:   if (u_done) state_next = B_PROD;
      B_PROD:  if (iss_done && !pv) state_next = B_ROWS;
      B_ROWS:  if (row == 2'd3) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      issued <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == B_ROWS);
      if (u_done)    issued <= 1'b0;
      else if (u_go) issued <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    unique case (state)
      B_IDLE: if (job_valid) begin
        eye  <= job.eye;
        dir  <= job.dir;
        zoom <= job.zoom;
        ok   <= 1'b1;
      end
      B_FWD: if (u_done) begin
        fwd <= uvec;
        ok  <= ok & u_ok;
      end
      B_SIDE: if (u_done) begin
        side <= uvec;
        ok   <= ok & u_ok;
        cnt  <= 3'd0;
      end
      B_CROSS: begin
        cnt <= cnt + 3'd1;
        unique case (cnt)
          3'd1: cv[0] <= p[MW:0];
          3'd2: acc <= pext;
          3'd3: cv[1] <= diff[MW:0];
          3'd4: begin
            cv[2]    <= (~p[MW:0]) + 1'b1;
            ph       <= 1'b0;
            ax       <= 2'd0;
            cp       <= 2'd0;
            iss_done <= 1'b0;
            pv       <= 1'b0;
          end
          default: ;
        endcase
      end
      B_UPX: if (u_done) begin
        upx <= uvec;
        ok  <= ok & u_ok;
      end
      B_PROD: begin
        // issue one product a cycle
        pv <= !iss_done;
        if (!iss_done) begin
          pph <= ph;
          pax <= ax;
          pcp <= cp;
          if (cp == 2'd2) begin
            cp <= 2'd0;
            if (ax == 2'd2) begin
              ax <= 2'd0;
              if (ph) iss_done <= 1'b1;
              else    ph <= 1'b1;
            end else begin
              ax <= ax + 2'd1;
            end
          end else begin
            cp <= cp + 2'd1;
          end
        end
        // consume the registered product
        if (pv) begin
          if (!pph) begin
            ent[pcp][pax] <= rnd_sat(pext, 1'b0);
          end else begin
            acc <= dot;
            if (pcp == 2'd2) ent[3][pax] <= rnd_sat(dot, 1'b1);
          end
        end
        row <= 2'd0;
      end
      B_ROWS: begin
        result.row_index  <= row;
        result.col_zero   <= ent[row][0];
        result.col_one    <= ent[row][1];
        result.col_two    <= ent[row][2];
        result.col_three  <= (row == 2'd3) ? (32'd1 << FRAC_BITS) : 32'd0;
        result.degenerate <= !ok;
        result.last_row   <= (row == 2'd3);
        row               <= row + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/look_at_view_matrix_top.sv -----
// Look-at view matrix builder: top level joining the item queue and the back end.
//
// Takes an item (eye, target, zoom) when start is high and busy is low, and
// returns four row items, one per cycle, each marked by strobe for one cycle;
// the receiver cannot stall. A two-entry queue lets up to two items wait while
// the back end works. Each item makes three passes through the shared
// unit-vector engine (a one-bit-per-cycle prescale, a sum of squares,
// 31 integer-sqrt steps, 3 x (FRAC_BITS+1) divide steps), then the cross
// products and the scaling and dot products through one multiplier, then
// the four row outputs. A zero-length axis becomes zero and sets degenerate;
// its engine pass skips the squares, sqrt and divides, so such items
// finish sooner.
module look_at_view_matrix_top import lav_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      strobe,
  output out_item_t result
);

  job_t job;
  logic job_valid;
  logic pop;

  lav_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .pop       (pop),
    .job       (job),
    .job_valid (job_valid)
  );

  lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .pop       (pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
